[rtl/core/pcbst_pkg.sv]
// ----------------------------------------------------------------------------
// pcbst_pkg
// shared types and constants of the per-class box suppression table
// ----------------------------------------------------------------------------
package pcbst_pkg;

	localparam int CLASS_W   = 7;
	localparam int COORD_W   = 16;
	localparam int REMOVED_W = 5;
	localparam int THRESH_W  = 16;
	localparam int IN_DATA_W  = 88;  // 87 payload bits, padded to whole bytes
	localparam int OUT_DATA_W = 96;  // 95 payload bits, padded to whole bytes

	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd29491;

	// iou datapath widths, edges are in units of 2^-17
	localparam int EDGE_W  = 19;
	localparam int OVL_W   = 17;
	localparam int AREA_W  = 32;
	localparam int INTER_W = 34;
	localparam int UNION_W = 35;
	localparam int PROD_W  = 51;

	typedef enum logic [2:0] {
		STAT_STORED,
		STAT_SUPPRESSED,
		STAT_FULL,
		STAT_EXTRACTED,
		STAT_EMPTY
	} status_t;

	typedef enum logic [1:0] {
		CMD_INSERT,
		CMD_EXTRACT,
		CMD_BAD_CLASS
	} cmd_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_META_WAIT,
		BK_WALK,
		BK_FINISH,
		BK_SCAN,
		BK_POP_META,
		BK_POP_WAIT,
		BK_RESULT
	} back_state_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] h;
	} geom_t;

	typedef struct packed {
		geom_t              geom;
		logic [COORD_W-1:0] score;
	} box_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [CLASS_W-1:0] cls;
		box_t               box;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic [REMOVED_W-1:0] removed;
		logic [CLASS_W-1:0]   cls;
		box_t                 box;
		logic                 last;
	} res_t;

endpackage

[rtl/core/per_class_box_suppression_table_core.sv]
// ----------------------------------------------------------------------------
// per_class_box_suppression_table_core
// per-class iou suppression table with insert and extract commands
// ----------------------------------------------------------------------------
// items enter on the s_ stream: s_tuser low inserts a box into its class list,
// s_tuser high extracts the next stored box. every item gives exactly one
// result transaction on the m_ stream; m_tlast flags the box that empties the
// table. the overlap threshold is written on the cfg channel; the user must
// write it only while idle, the block itself does not enforce it. a two-entry
// command queue decouples the input from execution, so items are taken while
// a result still waits in the output register. an insert into a non-empty
// class reads its list metadata, walks the list with one stored box read per
// cycle into the five-stage iou pipeline, then pushes the new box and writes
// the result; an insert into an empty class skips the walk. an extract skips
// empty classes from the last drained class, at most NUM_CLASSES - 1, then
// pops the box and writes the result. an out-of-range class or an extract of
// an empty table goes straight to the result. items are executed one at a
// time, the next starts once the previous result sits in the output register.
// reset empties every class list at once (per-class occupancy flags), the
// stores themselves need no clearing pass. if the receiver stalls, the result
// holds in the output register and the queue fills, then s_tready drops.
// ----------------------------------------------------------------------------
module per_class_box_suppression_table_core import pcbst_pkg::*; #(
	parameter int NUM_CLASSES = 128,
	parameter int LIST_DEPTH  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream, tdata from bit 0: class_id, center_x, center_y, box_width,
	// box_height, confidence, zero pad
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,   // op: 0 insert, 1 extract
	// result stream, tdata from bit 0: status, removed_count, out_class,
	// out_x, out_y, out_width, out_height, out_score, zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,   // last: table emptied by this box
	// threshold register write, unsigned q0.16
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [THRESH_W-1:0]   cfg_data
);

	logic cmd_valid, cmd_ready;
	cmd_t cmd;
	res_t result;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	pcbst_front #(
		.NUM_CLASSES(NUM_CLASSES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	pcbst_back #(
		.NUM_CLASSES(NUM_CLASSES),
		.LIST_DEPTH (LIST_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.result    (result)
	);

	// pack the result, first field in the lowest bits
	assign m_tdata = {
		1'b0,
		result.box.score,
		result.box.geom.h,
		result.box.geom.w,
		result.box.geom.y,
		result.box.geom.x,
		result.cls,
		result.removed,
		result.status
	};
	assign m_tlast = result.last;

endmodule

[rtl/core/pcbst_ram.sv]
// ----------------------------------------------------------------------------
// pcbst_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pcbst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/pcbst_iou.sv]
// ----------------------------------------------------------------------------
// pcbst_iou
// five-stage overlap test of the new box against one stored box per cycle
// ----------------------------------------------------------------------------
module pcbst_iou import pcbst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  box_t                in_box,
	input  geom_t               new_geom,
	input  logic [AREA_W-1:0]   new_area,
	input  logic [THRESH_W-1:0] thresh,
	output logic                out_valid,
	output logic                out_overlap,
	output box_t                out_box
);

	// overlap along one axis, clamped to zero when negative
	function automatic logic [OVL_W-1:0] axis_overlap(
		input logic [COORD_W-1:0] ca,
		input logic [COORD_W-1:0] wa,
		input logic [COORD_W-1:0] cb,
		input logic [COORD_W-1:0] wb
	);
		logic signed [EDGE_W-1:0] la, lb, ra, rb, lft, rgt;
		logic signed [EDGE_W:0]   d;
		la  = $signed({2'b00, ca, 1'b0}) - $signed({3'b000, wa});
		lb  = $signed({2'b00, cb, 1'b0}) - $signed({3'b000, wb});
		ra  = $signed({2'b00, ca, 1'b0}) + $signed({3'b000, wa});
		rb  = $signed({2'b00, cb, 1'b0}) + $signed({3'b000, wb});
		lft = (la > lb) ? la : lb;
		rgt = (ra < rb) ? ra : rb;
		d   = $signed({rgt[EDGE_W-1], rgt}) - $signed({lft[EDGE_W-1], lft});
		return d[EDGE_W] ? '0 : d[OVL_W-1:0];
	endfunction

	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	box_t                box_s1, box_s2, box_s3, box_s4, box_s5;
	logic [OVL_W-1:0]    ow_s1, oh_s1;
	logic [AREA_W-1:0]   area_s1;
	logic [INTER_W-1:0]  inter_s2, inter_s3, inter_s4;
	logic [UNION_W-1:0]  sum_s2, uni_s3;
	logic [PROD_W-1:0]   prod_s4;
	logic                nz_s4, ov_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// edges and overlaps, stored box area
		ow_s1   <= axis_overlap(new_geom.x, new_geom.w, in_box.geom.x, in_box.geom.w);
		oh_s1   <= axis_overlap(new_geom.y, new_geom.h, in_box.geom.y, in_box.geom.h);
		area_s1 <= in_box.geom.w * in_box.geom.h;
		box_s1  <= in_box;
		// intersection and area sum
		inter_s2 <= ow_s1 * oh_s1;
		sum_s2   <= (UNION_W'(new_area) + UNION_W'(area_s1)) << 2;
		box_s2   <= box_s1;
		// union
		uni_s3   <= sum_s2 - UNION_W'(inter_s2);
		inter_s3 <= inter_s2;
		box_s3   <= box_s2;
		// threshold times union
		prod_s4  <= PROD_W'(thresh) * PROD_W'(uni_s3);
		nz_s4    <= (uni_s3 != '0);
		inter_s4 <= inter_s3;
		box_s4   <= box_s3;
		// final compare, zero union never overlaps
		ov_s5    <= nz_s4 && (PROD_W'({inter_s4, 16'h0000}) > prod_s4);
		box_s5   <= box_s4;
	end

	assign out_valid   = v_s5;
	assign out_overlap = ov_s5;
	assign out_box     = box_s5;

endmodule

[rtl/core/pcbst_front.sv]
// ----------------------------------------------------------------------------
// pcbst_front
// input side: unpacks and classifies items into a two-entry command queue
// ----------------------------------------------------------------------------
module pcbst_front import pcbst_pkg::*; #(
	parameter int NUM_CLASSES = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cmd_t                 cmd
);

	cmd_t       in_cmd;
	cmd_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	always_comb begin
		in_cmd.cls           = s_tdata[6:0];
		in_cmd.box.geom.x    = s_tdata[22:7];
		in_cmd.box.geom.y    = s_tdata[38:23];
		in_cmd.box.geom.w    = s_tdata[54:39];
		in_cmd.box.geom.h    = s_tdata[70:55];
		in_cmd.box.score     = s_tdata[86:71];
		if (s_tuser) begin
			in_cmd.kind = CMD_EXTRACT;
		end else if (int'(s_tdata[6:0]) >= NUM_CLASSES) begin
			in_cmd.kind = CMD_BAD_CLASS;
		end else begin
			in_cmd.kind = CMD_INSERT;
		end
	end

	assign s_tready  = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

[rtl/core/pcbst_back.sv]
// ----------------------------------------------------------------------------
// pcbst_back
// execution side: list walk with compaction, push, pop and the result register
// ----------------------------------------------------------------------------
module pcbst_back import pcbst_pkg::*; #(
	parameter int NUM_CLASSES = 128,
	parameter int LIST_DEPTH  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  cmd_t                cmd,
	input  logic                cfg_valid,
	input  logic [THRESH_W-1:0] cfg_data,
	output logic                m_tvalid,
	input  logic                m_tready,
	output res_t                result
);

	localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int SLOT_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int FILL_W  = $clog2(LIST_DEPTH + 1);
	localparam int ENTRIES = NUM_CLASSES * LIST_DEPTH;
	localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int TOTAL_W = $clog2(ENTRIES + 1);
	localparam int BOX_W   = $bits(box_t);

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic [SLOT_W-1:0] head;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	function automatic logic [SLOT_W-1:0] slot_back(
		input logic [SLOT_W-1:0] head,
		input logic [FILL_W-1:0] off
	);
		int s;
		s = int'(head) - int'(off);
		if (s < 0) begin
			s = s + LIST_DEPTH;
		end
		return SLOT_W'(s);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] head);
		return (int'(head) == LIST_DEPTH - 1) ? '0 : SLOT_W'(int'(head) + 1);
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(
		input logic [CLS_W-1:0]  cls,
		input logic [SLOT_W-1:0] slot
	);
		return ADDR_W'(int'(cls) * LIST_DEPTH + int'(slot));
	endfunction

	back_state_t state_q, state_d;

	logic [THRESH_W-1:0]    thresh_q;
	cmd_t                   cur_q;
	logic [CLS_W-1:0]       cls_q, scan_q, drain_q;
	logic [AREA_W-1:0]      new_area_q;
	logic [FILL_W-1:0]      fill_q, issued_q, done_q, removed_q, keep_q;
	logic [SLOT_W-1:0]      head_q;
	logic                   supp_q;
	logic [NUM_CLASSES-1:0] ne_q;
	logic [TOTAL_W-1:0]     total_q;
	logic                   walk_rd_s0;
	res_t                   pend_q, out_q;
	res_t                   idle_res;
	logic                   out_valid_q;

	// memories
	logic              box_we, meta_we;
	logic [ADDR_W-1:0] box_waddr, box_raddr;
	logic [BOX_W-1:0]  box_wdata, box_rdata;
	logic [CLS_W-1:0]  meta_waddr, meta_raddr;
	meta_t             meta_wdata, meta_rd;
	logic [META_W-1:0] meta_rdata;

	// iou pipeline
	logic dec_valid, dec_overlap;
	box_t dec_box;
	logic hit, remove, suppress;

	// finish and walk helpers
	logic [FILL_W-1:0] remain, start_fill;
	logic              store_ok;
	logic [SLOT_W-1:0] head_inc;
	logic              issue;

	assign meta_rd    = meta_t'(meta_rdata);
	assign start_fill = ne_q[cls_q] ? meta_rd.fill : '0;
	assign remain     = fill_q - removed_q;
	assign store_ok   = !supp_q && (remain != FILL_W'(LIST_DEPTH));
	assign head_inc   = slot_next(head_q);
	assign issue      = (state_q == BK_WALK) && (issued_q < fill_q);

	assign hit      = dec_valid && dec_overlap && !supp_q;
	assign remove   = hit && (cur_q.box.score > dec_box.score);
	assign suppress = hit && !remove;

	// default result of a fresh command, fields filled in later
	always_comb begin
		idle_res        = '0;
		idle_res.status = (cmd.kind == CMD_EXTRACT) ? STAT_EMPTY : STAT_FULL;
	end

	pcbst_ram #(
		.WIDTH(BOX_W),
		.DEPTH(ENTRIES)
	) u_box_ram (
		.clk   (clk),
		.we    (box_we),
		.waddr (box_waddr),
		.wdata (box_wdata),
		.raddr (box_raddr),
		.rdata (box_rdata)
	);

	pcbst_ram #(
		.WIDTH(META_W),
		.DEPTH(NUM_CLASSES)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	pcbst_iou u_iou (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (walk_rd_s0),
		.in_box      (box_t'(box_rdata)),
		.new_geom    (cur_q.box.geom),
		.new_area    (new_area_q),
		.thresh      (thresh_q),
		.out_valid   (dec_valid),
		.out_overlap (dec_overlap),
		.out_box     (dec_box)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_INSERT:  state_d = BK_META_WAIT;
						CMD_EXTRACT: state_d = (total_q == '0) ? BK_RESULT : BK_SCAN;
						default:     state_d = BK_RESULT;
					endcase
				end
			end
			BK_META_WAIT: state_d = (start_fill == '0) ? BK_FINISH : BK_WALK;
			BK_WALK: begin
				if (dec_valid && (done_q + 1'b1 == fill_q)) begin
					state_d = BK_FINISH;
				end
			end
			BK_FINISH:   state_d = BK_RESULT;
			BK_SCAN:     state_d = ne_q[scan_q] ? BK_POP_META : BK_SCAN;
			BK_POP_META: state_d = BK_POP_WAIT;
			BK_POP_WAIT: state_d = BK_RESULT;
			BK_RESULT: begin
				if (!out_valid_q || m_tready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd_ready  = (state_q == BK_IDLE);
		meta_raddr = (state_q == BK_SCAN) ? scan_q : CLS_W'(cmd.cls);
		box_raddr  = addr_of(cls_q, slot_back(head_q, issued_q));
		box_we     = 1'b0;
		box_waddr  = addr_of(cls_q, slot_back(head_q, keep_q));
		box_wdata  = dec_box;
		meta_we    = 1'b0;
		meta_waddr = cls_q;
		meta_wdata = '{fill: remain, head: head_q};
		unique case (state_q)
			BK_WALK: begin
				// survivors are compacted toward the newest end
				box_we = dec_valid && !remove;
			end
			BK_FINISH: begin
				meta_we = 1'b1;
				if (store_ok) begin
					box_we     = 1'b1;
					box_waddr  = addr_of(cls_q, head_inc);
					box_wdata  = cur_q.box;
					meta_wdata = '{fill: remain + 1'b1, head: head_inc};
				end
			end
			BK_POP_META: begin
				box_raddr = addr_of(scan_q, meta_rd.head);
			end
			BK_POP_WAIT: begin
				meta_we    = 1'b1;
				meta_waddr = scan_q;
				meta_wdata = '{fill: fill_q - 1'b1, head: slot_back(head_q, FILL_W'(1))};
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			thresh_q    <= THRESH_RESET;
			ne_q        <= '0;
			total_q     <= '0;
			drain_q     <= '0;
			scan_q      <= '0;
			issued_q    <= '0;
			done_q      <= '0;
			removed_q   <= '0;
			keep_q      <= '0;
			supp_q      <= 1'b0;
			walk_rd_s0  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			walk_rd_s0 <= issue;
			if (cfg_valid) begin
				thresh_q <= cfg_data;
			end
			if (meta_we) begin
				ne_q[meta_waddr] <= (meta_wdata.fill != '0);
			end
			// output register loads a new result or empties on a transaction
			if (state_q == BK_RESULT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (cmd_valid) begin
						issued_q  <= '0;
						done_q    <= '0;
						removed_q <= '0;
						keep_q    <= '0;
						supp_q    <= 1'b0;
						scan_q    <= drain_q;
						if (cmd.kind == CMD_EXTRACT && total_q == '0) begin
							drain_q <= '0;
						end
					end
				end
				BK_WALK: begin
					if (issue) begin
						issued_q <= issued_q + 1'b1;
					end
					if (dec_valid) begin
						done_q <= done_q + 1'b1;
					end
					if (remove) begin
						removed_q <= removed_q + 1'b1;
					end else if (dec_valid) begin
						keep_q <= keep_q + 1'b1;
					end
					if (suppress) begin
						supp_q <= 1'b1;
					end
				end
				BK_FINISH: begin
					total_q <= total_q - TOTAL_W'(removed_q) + TOTAL_W'(store_ok);
				end
				BK_SCAN: begin
					if (!ne_q[scan_q]) begin
						scan_q <= (int'(scan_q) == NUM_CLASSES - 1) ? '0
							: CLS_W'(int'(scan_q) + 1);
					end
				end
				BK_POP_WAIT: begin
					total_q <= total_q - 1'b1;
					drain_q <= (total_q == TOTAL_W'(1)) ? '0 : scan_q;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cur_q      <= cmd;
					cls_q      <= CLS_W'(cmd.cls);
					new_area_q <= cmd.box.geom.w * cmd.box.geom.h;
					pend_q     <= idle_res;
				end
			end
			BK_META_WAIT: begin
				fill_q <= start_fill;
				head_q <= ne_q[cls_q] ? meta_rd.head : '0;
			end
			BK_FINISH: begin
				pend_q.removed <= REMOVED_W'(removed_q);
				if (supp_q) begin
					pend_q.status <= STAT_SUPPRESSED;
				end else if (store_ok) begin
					pend_q.status <= STAT_STORED;
				end else begin
					pend_q.status <= STAT_FULL;
				end
			end
			BK_POP_META: begin
				fill_q <= meta_rd.fill;
				head_q <= meta_rd.head;
			end
			BK_POP_WAIT: begin
				pend_q.status <= STAT_EXTRACTED;
				pend_q.cls    <= CLASS_W'(scan_q);
				pend_q.box    <= box_t'(box_rdata);
				pend_q.last   <= (total_q == TOTAL_W'(1));
			end
			BK_RESULT: begin
				if (!out_valid_q || m_tready) begin
					out_q <= pend_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign result   = out_q;

endmodule

[rtl/core/pcbst_checker.sv]
// ----------------------------------------------------------------------------
// pcbst_checker
// port-level checks of the suppression table, bound to the top level
// ----------------------------------------------------------------------------
module pcbst_checker import pcbst_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= STAT_EMPTY)
		else $error("status code out of range");

	a_last_extract: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[2:0] == STAT_EXTRACTED)
		else $error("last flag on a non-extract result");

	// insert results carry no box, extract results remove nothing
	a_insert_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == STAT_STORED || m_tdata[2:0] == STAT_SUPPRESSED
			|| m_tdata[2:0] == STAT_FULL) |-> m_tdata[94:8] == '0 && !m_tlast)
		else $error("insert result carries box fields");

	a_extract_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == STAT_EXTRACTED || m_tdata[2:0] == STAT_EMPTY)
			|-> m_tdata[7:3] == '0)
		else $error("extract result reports removals");

endmodule

bind per_class_box_suppression_table_core pcbst_checker u_pcbst_checker (.*);

[tb/per_class_box_suppression_table_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_box_suppression_table_core_test
// self-checking bench for the per-class iou suppression table
// ----------------------------------------------------------------------------
// inserts and extracts are streamed in bursts while the result side stalls on
// its own pattern. a scoreboard keeps a shadow copy of every class list and
// the threshold, predicts one result per accepted transaction and compares
// each result field by field. the threshold is rewritten between phases, once
// the table has gone quiet.
// ----------------------------------------------------------------------------
module per_class_box_suppression_table_core_test;
	import pcbst_pkg::*;

	localparam int N_CLS = 128;
	localparam int DEPTH = 16;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  removed;
		logic [6:0]  cls;
		logic [15:0] x, y, w, h, score;
		logic        last;
	} outcome_t;

	// shadow of the class lists plus the iou rule
	class nms_scoreboard;
		logic [15:0] gx[N_CLS][DEPTH], gy[N_CLS][DEPTH], gw[N_CLS][DEPTH];
		logic [15:0] gh[N_CLS][DEPTH], gs[N_CLS][DEPTH];
		int          fill[N_CLS];
		int          drain;
		logic [15:0] thresh;
		outcome_t    pending[$];
		int          errors;

		function void reset_state();
			foreach (fill[c]) fill[c] = 0;
			drain = 0;
			thresh = THRESH_RESET;
			pending.delete();
			errors = 0;
		endfunction

		function longint span(longint ca, longint wa, longint cb, longint wb);
			longint l, r;
			l = (2*ca - wa) > (2*cb - wb) ? (2*ca - wa) : (2*cb - wb);
			r = (2*ca + wa) < (2*cb + wb) ? (2*ca + wa) : (2*cb + wb);
			return r - l;
		endfunction

		function bit overlaps(logic [15:0] x, y, w, h, int c, int i);
			longint ow, oh, inter, uni;
			ow = span(x, w, gx[c][i], gw[c][i]);
			oh = span(y, h, gy[c][i], gh[c][i]);
			inter = (ow < 0 || oh < 0) ? 0 : ow * oh;
			uni = 4*longint'(w)*h + 4*longint'(gw[c][i])*gh[c][i] - inter;
			if (uni <= 0) return 0;
			return inter * 65536 > longint'(thresh) * uni;
		endfunction

		function void drop_entry(int c, int i);
			for (int k = i; k + 1 < fill[c]; k++) begin
				gx[c][k] = gx[c][k+1]; gy[c][k] = gy[c][k+1];
				gw[c][k] = gw[c][k+1]; gh[c][k] = gh[c][k+1];
				gs[c][k] = gs[c][k+1];
			end
			fill[c]--;
		endfunction

		// note an accepted input transaction and queue its outcome
		function void note_input(bit extract, logic [6:0] c,
				logic [15:0] x, y, w, h, s);
			outcome_t o;
			int i, removed, found;
			o = '0;
			if (!extract) begin
				i = 0; removed = 0;
				o.status = STAT_STORED;
				while (i < fill[c]) begin
					if (overlaps(x, y, w, h, c, i)) begin
						if (s > gs[c][i]) begin
							drop_entry(c, i);
							removed++;
							continue;
						end
						o.status = STAT_SUPPRESSED;
						break;
					end
					i++;
				end
				if (o.status == STAT_STORED && fill[c] >= DEPTH)
					o.status = STAT_FULL;
				if (o.status == STAT_STORED) begin
					for (int k = fill[c]; k > 0; k--) begin
						gx[c][k] = gx[c][k-1]; gy[c][k] = gy[c][k-1];
						gw[c][k] = gw[c][k-1]; gh[c][k] = gh[c][k-1];
						gs[c][k] = gs[c][k-1];
					end
					gx[c][0] = x; gy[c][0] = y; gw[c][0] = w; gh[c][0] = h;
					gs[c][0] = s;
					fill[c]++;
				end
				o.removed = 5'(removed);
			end else begin
				found = -1;
				for (int n = 0; n < N_CLS; n++)
					if (found < 0 && fill[(drain + n) % N_CLS] != 0)
						found = (drain + n) % N_CLS;
				if (found < 0) begin
					drain = 0;
					o.status = STAT_EMPTY;
				end else begin
					o.status = STAT_EXTRACTED;
					o.cls = 7'(found);
					o.x = gx[found][0]; o.y = gy[found][0];
					o.w = gw[found][0]; o.h = gh[found][0];
					o.score = gs[found][0];
					drop_entry(found, 0);
					drain = found;
					o.last = 1;
					foreach (fill[k]) if (fill[k] != 0) o.last = 0;
					if (o.last) drain = 0;
				end
			end
			pending.push_back(o);
		endfunction

		function void check_result(outcome_t got);
			outcome_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp = pending[0];
			pending.delete(0);
			if (got.status !== exp.status)
				$display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
			if (got.removed !== exp.removed)
				$display("%0t: removed exp %0d got %0d", $time, exp.removed, got.removed);
			if (got.cls !== exp.cls)
				$display("%0t: class exp %0d got %0d", $time, exp.cls, got.cls);
			if ({got.x, got.y, got.w, got.h} !== {exp.x, exp.y, exp.w, exp.h})
				$display("%0t: box exp %h got %h", $time,
					{exp.x, exp.y, exp.w, exp.h}, {got.x, got.y, got.w, got.h});
			if (got.score !== exp.score)
				$display("%0t: score exp %h got %h", $time, exp.score, got.score);
			if (got.last !== exp.last)
				$display("%0t: last exp %0d got %0d", $time, exp.last, got.last);
			if (got !== exp) errors++;
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  s_tvalid = 0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 0;
	logic                  m_tvalid;
	logic                  m_tready = 0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 0;
	logic                  cfg_ready;
	logic [THRESH_W-1:0]   cfg_data = '0;

	nms_scoreboard table_model = new();
	int  idle_cycles;
	int  gap_left, burst_left;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	per_class_box_suppression_table_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// result side: stall pattern with quiet stretches and heavy stretches
	int stall_phase = 0;
	always @(posedge clk) begin
		outcome_t got;
		if (m_tvalid && m_tready) begin
			got.status  = m_tdata[2:0];
			got.removed = m_tdata[7:3];
			got.cls     = m_tdata[14:8];
			got.x       = m_tdata[30:15];
			got.y       = m_tdata[46:31];
			got.w       = m_tdata[62:47];
			got.h       = m_tdata[78:63];
			got.score   = m_tdata[94:79];
			got.last    = m_tlast;
			table_model.check_result(got);
		end
		stall_phase <= (stall_phase + 1) % 400;
		if (stall_phase < 100) m_tready <= 1;
		else if (stall_phase < 250) m_tready <= ($urandom_range(0, 3) != 0);
		else m_tready <= ($urandom_range(0, 3) == 0);
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// called at a rising edge; the new item is driven at that same edge unless a gap between bursts comes first
	task automatic send_item(bit extract, logic [6:0] c,
			logic [15:0] x, y, w, h, s);
		// sender bursts: a gap between bursts of random length
		if (burst_left == 0) begin
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
			burst_left = $urandom_range(1, 12);
		end
		if (gap_left > 0) begin
			s_tvalid <= 0;
			while (gap_left > 0) begin
				@(posedge clk);
				gap_left--;
			end
		end
		s_tvalid <= 1;
		s_tuser  <= extract;
		s_tdata  <= {1'b0, s, h, w, y, x, c};
		do @(posedge clk); while (!s_tready);
		table_model.note_input(extract, c, x, y, w, h, s);
		burst_left--;
	endtask

	task automatic finish_input();
		s_tvalid <= 0;
	endtask

	task automatic wait_quiet();
		finish_input();
		while (table_model.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		table_model.thresh = v;
	endtask

	task automatic random_insert(int cls_hi, bit wide);
		logic [15:0] x, y, w, h;
		x = wide ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(30000, 34000));
		y = wide ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(30000, 34000));
		w = wide ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(2000, 9000));
		h = wide ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(2000, 9000));
		send_item(1'b0, 7'($urandom_range(0, cls_hi)), x, y, w, h,
			16'($urandom_range(0, 65535)));
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: send_item(1'b1, 7'($urandom_range(0, 127)), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				3: random_insert(127, 1);
				default: random_insert(3, 0);
			endcase
		end
	endtask

	initial begin
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		table_model.reset_state();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty extract, extremes, equal score suppression, full list
		send_item(1'b1, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_item(1'b0, 7'd127, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_item(1'b0, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);      // zero union
		send_item(1'b0, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd5);
		send_item(1'b0, 7'd5, 16'd32768, 16'd32768, 16'd8000, 16'd8000, 16'd100);
		// equal score drops
		send_item(1'b0, 7'd5, 16'd32768, 16'd32768, 16'd8000, 16'd8000, 16'd100);
		// removes older
		send_item(1'b0, 7'd5, 16'd32800, 16'd32768, 16'd8000, 16'd8000, 16'd200);
		for (int i = 0; i < 17; i++)                                 // fills, then full
			send_item(1'b0, 7'd9, 16'(i * 3800), 16'd1000, 16'd100, 16'd100, 16'(i));
		send_item(1'b1, 7'd0, 16'h5555, 16'haaaa, 16'd0, 16'd0, 16'd0);
		wait_quiet();

		write_threshold(16'h0000);
		random_phase(200);
		wait_quiet();
		write_threshold(16'hffff);
		random_phase(200);
		wait_quiet();
		write_threshold(16'h2000);
		random_phase(200);
		wait_quiet();
		write_threshold(THRESH_RESET);
		random_phase(200);
		for (int i = 0; i < 60; i++)                                 // extracts toward an empty table
			send_item(1'b1, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		wait_quiet();

		if (table_model.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[files.f]
rtl/core/pcbst_pkg.sv
rtl/core/pcbst_ram.sv
rtl/core/pcbst_iou.sv
rtl/core/pcbst_front.sv
rtl/core/pcbst_back.sv
rtl/core/per_class_box_suppression_table_core.sv
rtl/core/pcbst_checker.sv
tb/per_class_box_suppression_table_core_test.sv
